// ----- hw/rtl/vrp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared widths, register indexes and reset values of the vertex rotate and project block.
// It depends on nothing. It is used by vertex_rotate_project and its bench.
package vrp_pkg;

   // Screen center.
   localparam int CENTER_X = 320;
   localparam int CENTER_Y = 240;

   // Field widths.
   localparam int PT_W    = 24;
   localparam int TRIG_W  = 16;
   localparam int SCR_W   = 16;
   localparam int CSR_W   = 24;
   localparam int ADDR_W  = 3;

   // Datapath widths.
   localparam int DIFF_W  = PT_W + 1;            // vertex minus camera
   localparam int PROD_W  = DIFF_W + TRIG_W;     // one Q.22 product
   localparam int SUM1_W  = PROD_W + 1;          // yaw rotated values
   localparam int PROD2_W = SUM1_W + TRIG_W;     // Q.36 products
   localparam int ACC_W   = PROD2_W + 2;         // pitch sums with rounding
   localparam int ROT_W   = 32;                  // rotated values in Q.8
   localparam int NUM_W   = 56;                  // focal times magnitude
   localparam int DEN_W   = 40;                  // depth times 256
   localparam int QUO_W   = 17;                  // quotient bits kept
   localparam int DIV_W   = 58;                  // partial remainder width
   localparam int DIV_STEPS = QUO_W;
   localparam int OUT_W   = 20;                  // center plus signed quotient

   // Register indexes.
   localparam logic [ADDR_W-1:0] REG_COS_YAW   = 3'd0;
   localparam logic [ADDR_W-1:0] REG_SIN_YAW   = 3'd1;
   localparam logic [ADDR_W-1:0] REG_COS_PITCH = 3'd2;
   localparam logic [ADDR_W-1:0] REG_SIN_PITCH = 3'd3;
   localparam logic [ADDR_W-1:0] REG_CAM_X     = 3'd4;
   localparam logic [ADDR_W-1:0] REG_CAM_Y     = 3'd5;
   localparam logic [ADDR_W-1:0] REG_CAM_Z     = 3'd6;
   localparam logic [ADDR_W-1:0] REG_FOCAL     = 3'd7;

   // Reset values.
   localparam logic signed [TRIG_W-1:0] RST_COS   = 16'sd16384;
   localparam logic signed [TRIG_W-1:0] RST_SIN   = 16'sd0;
   localparam logic signed [PT_W-1:0]   RST_CAM_X = 24'sd2560;
   localparam logic signed [PT_W-1:0]   RST_CAM_Y = 24'sd1280;
   localparam logic signed [PT_W-1:0]   RST_CAM_Z = 24'sd0;
   localparam logic [CSR_W-1:0]         RST_FOCAL = 24'd106416;

endpackage
`default_nettype wire

// ----- hw/rtl/vertex_rotate_project.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Vertex transform: camera offset, yaw and pitch rotation, perspective divide.
// Depends on vrp_pkg for widths, register indexes and reset values.
// Throughput is one request per cycle; the pipeline of multiplier stages and the
// 17 step restoring divider advance together, stalling only while a result waits.
// Reset is synchronous and active high; it clears valid bits and loads register defaults.
module vertex_rotate_project
   import vrp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output      logic              req_tready,
   input  wire logic [71:0]       req_tdata,   // pt_x [23:0], pt_y [47:24], pt_z [71:48]
   input  wire logic              req_tlast,   // last_in
   output      logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   output      logic [31:0]       rsp_tdata,   // screen_x [15:0], screen_y [31:16]
   output      logic              rsp_tuser,   // behind
   output      logic              rsp_tlast,   // last_out
   input  wire logic              csr_we,
   input  wire logic [ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_W-1:0]  csr_wdata
);

   // Configuration registers.
   logic signed [TRIG_W-1:0] cos_yaw_ff, sin_yaw_ff, cos_pitch_ff, sin_pitch_ff;
   logic signed [PT_W-1:0]   cam_x_ff, cam_y_ff, cam_z_ff;
   logic [CSR_W-1:0]         focal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_yaw_ff   <= RST_COS;
         sin_yaw_ff   <= RST_SIN;
         cos_pitch_ff <= RST_COS;
         sin_pitch_ff <= RST_SIN;
         cam_x_ff     <= RST_CAM_X;
         cam_y_ff     <= RST_CAM_Y;
         cam_z_ff     <= RST_CAM_Z;
         focal_ff     <= RST_FOCAL;
      end else if (csr_we) begin
         case (csr_addr)
            REG_COS_YAW:   cos_yaw_ff   <= csr_wdata[TRIG_W-1:0];
            REG_SIN_YAW:   sin_yaw_ff   <= csr_wdata[TRIG_W-1:0];
            REG_COS_PITCH: cos_pitch_ff <= csr_wdata[TRIG_W-1:0];
            REG_SIN_PITCH: sin_pitch_ff <= csr_wdata[TRIG_W-1:0];
            REG_CAM_X:     cam_x_ff     <= csr_wdata[PT_W-1:0];
            REG_CAM_Y:     cam_y_ff     <= csr_wdata[PT_W-1:0];
            REG_CAM_Z:     cam_z_ff     <= csr_wdata[PT_W-1:0];
            REG_FOCAL:     focal_ff     <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // The whole pipeline moves when the output register is free or being drained.
   logic en;
   logic rsp_valid_ff;
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // Stage 1: subtract the camera position.
   logic                     v1_ff, l1_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dz_ff;

   // Stage 2: yaw products and the pitch products of dy.
   logic                     v2_ff, l2_ff;
   logic signed [PROD_W-1:0] dxcy_ff, dzsy_ff, dzcy_ff, dxsy_ff, dycp_ff, dysp_ff;

   // Stage 3: yaw sums.
   logic                     v3_ff, l3_ff;
   logic signed [SUM1_W-1:0] xr3_ff, z1_ff;
   logic signed [PROD_W-1:0] dycp3_ff, dysp3_ff;

   // Stage 4: pitch products of the rotated depth.
   logic                      v4_ff, l4_ff;
   logic signed [SUM1_W-1:0]  xr4_ff;
   logic signed [PROD2_W-1:0] z1sp_ff, z1cp_ff;
   logic signed [PROD_W-1:0]  dycp4_ff, dysp4_ff;

   // Stage 5: pitch sums and rounding to Q.8.
   logic                    v5_ff, l5_ff;
   logic signed [ROT_W-1:0] rx_ff, ry_ff, rz_ff;
   logic signed [ACC_W-1:0] by_acc, bz_acc;
   logic signed [ACC_W-1:0] rx_acc;

   // Stage 6: focal products of the magnitudes and the divisor.
   logic                    v6_ff, l6_ff, b6_ff, nx6_ff, ny6_ff;
   logic [NUM_W-1:0]        numx_ff, numy_ff;
   logic [DEN_W-1:0]        den6_ff;
   logic [ROT_W-2:0]        ax_mag, ay_mag;

   always_comb begin
      by_acc = (ACC_W'(dycp4_ff) <<< 14) - ACC_W'(z1sp_ff) + (ACC_W'(1) <<< 27);
      bz_acc = (ACC_W'(dysp4_ff) <<< 14) + ACC_W'(z1cp_ff) + (ACC_W'(1) <<< 27);
      rx_acc = ACC_W'(xr4_ff) + (ACC_W'(1) <<< 13);
      ax_mag = rx_ff[ROT_W-1] ? (ROT_W-1)'(-rx_ff) : rx_ff[ROT_W-2:0];
      ay_mag = ry_ff[ROT_W-1] ? (ROT_W-1)'(-ry_ff) : ry_ff[ROT_W-2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l1_ff <= req_tlast;
         dx_ff <= DIFF_W'($signed(req_tdata[23:0])) - DIFF_W'(cam_x_ff);
         dy_ff <= DIFF_W'($signed(req_tdata[47:24])) - DIFF_W'(cam_y_ff);
         dz_ff <= DIFF_W'($signed(req_tdata[71:48])) - DIFF_W'(cam_z_ff);

         l2_ff   <= l1_ff;
         dxcy_ff <= dx_ff * cos_yaw_ff;
         dzsy_ff <= dz_ff * sin_yaw_ff;
         dzcy_ff <= dz_ff * cos_yaw_ff;
         dxsy_ff <= dx_ff * sin_yaw_ff;
         dycp_ff <= dy_ff * cos_pitch_ff;
         dysp_ff <= dy_ff * sin_pitch_ff;

         l3_ff    <= l2_ff;
         xr3_ff   <= SUM1_W'(dxcy_ff) + SUM1_W'(dzsy_ff);
         z1_ff    <= SUM1_W'(dzcy_ff) - SUM1_W'(dxsy_ff);
         dycp3_ff <= dycp_ff;
         dysp3_ff <= dysp_ff;

         l4_ff    <= l3_ff;
         xr4_ff   <= xr3_ff;
         z1sp_ff  <= z1_ff * sin_pitch_ff;
         z1cp_ff  <= z1_ff * cos_pitch_ff;
         dycp4_ff <= dycp3_ff;
         dysp4_ff <= dysp3_ff;

         l5_ff <= l4_ff;
         rx_ff <= ROT_W'(rx_acc >>> 14);
         ry_ff <= ROT_W'(by_acc >>> 28);
         rz_ff <= ROT_W'(bz_acc >>> 28);

         l6_ff   <= l5_ff;
         b6_ff   <= (rz_ff <= 0);
         nx6_ff  <= rx_ff[ROT_W-1];
         ny6_ff  <= ry_ff[ROT_W-1];
         numx_ff <= NUM_W'(focal_ff) * NUM_W'(ax_mag);
         numy_ff <= NUM_W'(focal_ff) * NUM_W'(ay_mag);
         den6_ff <= {DEN_W'(rz_ff[ROT_W-2:0])} << 8;
      end
   end

   // Restoring divider: entry 0 holds the overflow check, each later entry one quotient bit.
   logic             dv_v_ff  [0:DIV_STEPS];
   logic             dv_l_ff  [0:DIV_STEPS];
   logic             dv_b_ff  [0:DIV_STEPS];
   logic             dv_nx_ff [0:DIV_STEPS];
   logic             dv_ny_ff [0:DIV_STEPS];
   logic             dv_ox_ff [0:DIV_STEPS];
   logic             dv_oy_ff [0:DIV_STEPS];
   logic [DEN_W-1:0] dv_d_ff  [0:DIV_STEPS];
   logic [DIV_W-1:0] dv_rx_ff [0:DIV_STEPS];
   logic [DIV_W-1:0] dv_ry_ff [0:DIV_STEPS];
   logic [QUO_W-1:0] dv_qx_ff [0:DIV_STEPS];
   logic [QUO_W-1:0] dv_qy_ff [0:DIV_STEPS];
   logic [DIV_W-1:0] dv_rx_in [0:DIV_STEPS];
   logic [DIV_W-1:0] dv_ry_in [0:DIV_STEPS];
   logic [QUO_W-1:0] dv_qx_in [0:DIV_STEPS];
   logic [QUO_W-1:0] dv_qy_in [0:DIV_STEPS];
   logic [DIV_W-1:0] lim6;

   always_comb begin
      logic [DIV_W-1:0] trial;
      lim6        = DIV_W'(den6_ff) << QUO_W;
      dv_rx_in[0] = DIV_W'(numx_ff);
      dv_ry_in[0] = DIV_W'(numy_ff);
      dv_qx_in[0] = '0;
      dv_qy_in[0] = '0;
      trial       = '0;
      for (int k = 1; k <= DIV_STEPS; k++) begin
         trial       = DIV_W'(dv_d_ff[k-1]) << (DIV_STEPS - k);
         dv_rx_in[k] = dv_rx_ff[k-1];
         dv_ry_in[k] = dv_ry_ff[k-1];
         dv_qx_in[k] = dv_qx_ff[k-1];
         dv_qy_in[k] = dv_qy_ff[k-1];
         if (dv_rx_ff[k-1] >= trial) begin
            dv_rx_in[k] = dv_rx_ff[k-1] - trial;
            dv_qx_in[k][DIV_STEPS-k] = 1'b1;
         end
         if (dv_ry_ff[k-1] >= trial) begin
            dv_ry_in[k] = dv_ry_ff[k-1] - trial;
            dv_qy_in[k][DIV_STEPS-k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            dv_v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         dv_v_ff[0] <= v6_ff;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            dv_v_ff[k] <= dv_v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_l_ff[0]  <= l6_ff;
         dv_b_ff[0]  <= b6_ff;
         dv_nx_ff[0] <= nx6_ff;
         dv_ny_ff[0] <= ny6_ff;
         dv_ox_ff[0] <= (DIV_W'(numx_ff) >= lim6);
         dv_oy_ff[0] <= (DIV_W'(numy_ff) >= lim6);
         dv_d_ff[0]  <= den6_ff;
         for (int k = 0; k <= DIV_STEPS; k++) begin
            dv_rx_ff[k] <= dv_rx_in[k];
            dv_ry_ff[k] <= dv_ry_in[k];
            dv_qx_ff[k] <= dv_qx_in[k];
            dv_qy_ff[k] <= dv_qy_in[k];
         end
         for (int k = 1; k <= DIV_STEPS; k++) begin
            dv_l_ff[k]  <= dv_l_ff[k-1];
            dv_b_ff[k]  <= dv_b_ff[k-1];
            dv_nx_ff[k] <= dv_nx_ff[k-1];
            dv_ny_ff[k] <= dv_ny_ff[k-1];
            dv_ox_ff[k] <= dv_ox_ff[k-1];
            dv_oy_ff[k] <= dv_oy_ff[k-1];
            dv_d_ff[k]  <= dv_d_ff[k-1];
         end
      end
   end

   // Final stage: apply signs, offset by the center and saturate.
   logic signed [OUT_W-1:0] mag_x, mag_y, sum_x, sum_y;
   logic signed [SCR_W-1:0] sat_x, sat_y;
   logic [SCR_W-1:0]        scr_x_ff, scr_y_ff;
   logic                    behind_ff, last_ff;

   always_comb begin
      mag_x = dv_ox_ff[DIV_STEPS] ? (OUT_W'(1) <<< QUO_W) : OUT_W'(dv_qx_ff[DIV_STEPS]);
      mag_y = dv_oy_ff[DIV_STEPS] ? (OUT_W'(1) <<< QUO_W) : OUT_W'(dv_qy_ff[DIV_STEPS]);
      sum_x = dv_nx_ff[DIV_STEPS] ? OUT_W'(CENTER_X) - mag_x : OUT_W'(CENTER_X) + mag_x;
      sum_y = dv_ny_ff[DIV_STEPS] ? OUT_W'(CENTER_Y) + mag_y : OUT_W'(CENTER_Y) - mag_y;
      if (sum_x > OUT_W'(32767)) begin
         sat_x = 16'sh7FFF;
      end else if (sum_x < -OUT_W'(32768)) begin
         sat_x = -16'sh8000;
      end else begin
         sat_x = sum_x[SCR_W-1:0];
      end
      if (sum_y > OUT_W'(32767)) begin
         sat_y = 16'sh7FFF;
      end else if (sum_y < -OUT_W'(32768)) begin
         sat_y = -16'sh8000;
      end else begin
         sat_y = sum_y[SCR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_v_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         behind_ff <= dv_b_ff[DIV_STEPS];
         last_ff   <= dv_l_ff[DIV_STEPS];
         scr_x_ff  <= dv_b_ff[DIV_STEPS] ? '0 : sat_x;
         scr_y_ff  <= dv_b_ff[DIV_STEPS] ? '0 : sat_y;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {scr_y_ff, scr_x_ff};
   assign rsp_tuser  = behind_ff;
   assign rsp_tlast  = last_ff;

   // A vertex behind the camera always reports a zero screen point.
   a_behind_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("behind result with nonzero coordinates");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !dv_v_ff[DIV_STEPS] && !v6_ff)
      else $error("valid bit survived reset");

   // A stall freezes the last divider valid bit and the stage 1 valid bit.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(dv_v_ff[DIV_STEPS]) && $stable(v1_ff))
      else $error("pipeline moved during stall");

   // Without overflow, for a vertex in front of the camera, the x remainder ends below the divisor.
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      dv_v_ff[DIV_STEPS] && !dv_b_ff[DIV_STEPS] && !dv_ox_ff[DIV_STEPS]
      |-> dv_rx_ff[DIV_STEPS] < DIV_W'(dv_d_ff[DIV_STEPS]))
      else $error("divider remainder not reduced");

endmodule
`default_nettype wire

// ----- bench/vertex_rotate_project_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for vertex_rotate_project: camera offset, yaw and pitch rotation, projection.
// Depends on vrp_pkg and the block; expected points: typed table rows, else an in-bench model.
module vertex_rotate_project_test;
   import vrp_pkg::*;

   typedef struct packed {
      logic signed [15:0] scr_x;
      logic signed [15:0] scr_y;
      logic               behind;
      logic               last;
   } point_type;

   typedef struct {
      logic signed [23:0] px, py, pz;
      logic               last;
      bit                 typed;
      point_type          want;
   } vec_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [71:0]       req_tdata = '0;
   logic              req_tlast = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;
   logic              rsp_tuser;
   logic              rsp_tlast;
   logic              csr_we = 1'b0;
   logic [ADDR_W-1:0] csr_addr = '0;
   logic [CSR_W-1:0]  csr_wdata = '0;

   // Shadow copy of the configuration registers.
   longint cos_y, sin_y, cos_p, sin_p, cx, cy, cz, focal;

   point_type pending_points[$];
   int     mismatches = 0;
   int     checked = 0;
   int     sent = 0;
   int     idle_cycles = 0;
   int     send_idle = 0;
   int     recv_stall = 0;
   bit     done = 1'b0;

   // Idle percentages of the sender and the receiver in each phase.
   int     pct_send[5] = '{0, 85, 0, 36, 0};
   int     pct_recv[5] = '{0, 0, 85, 36, 0};

   localparam int WATCHDOG = 20000;

   vertex_rotate_project DUT (.*);

   always #5 clock = ~clock;

   function automatic longint floor_div28(longint v);
      return v >>> 28;
   endfunction

   function automatic longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Rotate the camera-relative vertex and project it onto the screen.
   function automatic point_type project_vertex(logic signed [23:0] px, logic signed [23:0] py,
                                                logic signed [23:0] pz, logic last);
      longint dx, dy, dz, xr, z1, rx, ry, rz, den, qx, qy;
      point_type p;
      dx = longint'(px) - cx;
      dy = longint'(py) - cy;
      dz = longint'(pz) - cz;
      xr = dx * cos_y + dz * sin_y;
      z1 = dz * cos_y - dx * sin_y;
      rx = floor_div28(xr * 16384 + (64'sd1 <<< 27));
      ry = floor_div28(dy * cos_p * 16384 - z1 * sin_p + (64'sd1 <<< 27));
      rz = floor_div28(dy * sin_p * 16384 + z1 * cos_p + (64'sd1 <<< 27));
      p.last = last;
      if (rz <= 0) begin
         p.behind = 1'b1;
         p.scr_x = '0;
         p.scr_y = '0;
      end else begin
         den = rz * 256;
         qx = (focal * rx) / den;
         qy = (focal * ry) / den;
         p.behind = 1'b0;
         p.scr_x = 16'(clamp16(CENTER_X + qx));
         p.scr_y = 16'(clamp16(CENTER_Y - qy));
      end
      return p;
   endfunction

   task automatic write_reg(logic [ADDR_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_COS_YAW:   cos_y = longint'($signed(val[15:0]));
         REG_SIN_YAW:   sin_y = longint'($signed(val[15:0]));
         REG_COS_PITCH: cos_p = longint'($signed(val[15:0]));
         REG_SIN_PITCH: sin_p = longint'($signed(val[15:0]));
         REG_CAM_X:     cx = longint'($signed(val));
         REG_CAM_Y:     cy = longint'($signed(val));
         REG_CAM_Z:     cz = longint'($signed(val));
         REG_FOCAL:     focal = longint'(val);
         default: ;
      endcase
   endtask

   // Offer one vertex request and hold it until the block takes it.
   task automatic send_vertex(logic signed [23:0] px, logic signed [23:0] py,
                              logic signed [23:0] pz, logic last, bit typed, point_type want);
      point_type p;
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      p = project_vertex(px, py, pz, last);
      if (typed && p !== want)
         $display("table row disagrees with transform model: %h vs %h", want, p);
      pending_points.push_back(typed ? want : p);
      req_tvalid <= 1'b1;
      req_tdata <= {pz, py, px};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // Result checking and receiver stalls.
   always @(posedge clock) begin
      point_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tuser, rsp_tlast};
            if (pending_points.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
               want = pending_points.pop_front();
               checked++;
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: x exp %0d got %0d, y exp %0d got %0d, ",
                               "behind %b/%b, last %b/%b"},
                              want.scr_x, got.scr_x, want.scr_y, got.scr_y,
                              want.behind, got.behind, want.last, got.last);
               end
            end
         end
         rsp_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
      end
   end

   // Watchdog on cycles with no accepted request or result.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset || done)
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG) begin
         $display("Regression FAIL");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   function automatic logic signed [23:0] rand_coord();
      case ($urandom_range(3))
         0: return 24'($urandom);
         1: return 24'($signed(12'($urandom)));
         default: return 24'($signed(20'($urandom)));
      endcase
   endfunction

   vec_row_type vec_table[] = '{
      '{24'sd2560, 24'sd1280, 24'sd256, 1'b0, 1'b1, '{16'sd320, 16'sd240, 1'b0, 1'b0}},
      '{24'sd2560, 24'sd1280, 24'sd0, 1'b1, 1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b1}},
      '{24'sd0, 24'sd0, -24'sd256, 1'b0, 1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b0}},
      '{24'sh7FFFFF, 24'sh7FFFFF, 24'sd1, 1'b0, 1'b1, '{16'sd32767, -16'sd32768, 1'b0, 1'b0}},
      '{24'sh800000, 24'sh800000, 24'sd1, 1'b1, 1'b1, '{-16'sd32768, 16'sd32767, 1'b0, 1'b1}},
      '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 1'b0, 1'b0, '{default:0}},
      '{24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1, 1'b0, '{default:0}},
      '{24'sh800000, 24'sh800000, 24'sh800000, 1'b0, 1'b0, '{default:0}},
      '{24'sd3000, 24'sd1000, 24'sd2560, 1'b0, 1'b0, '{default:0}},
      '{24'sd2000, 24'sd1500, 24'sd512, 1'b1, 1'b0, '{default:0}}
   };

   // Angle pairs (reset setting, extremes, full-scale, random in range), then camera and focal.
   task automatic random_config(int kind);
      case (kind)
         0: begin
            write_reg(REG_COS_YAW, 24'd16384); write_reg(REG_SIN_YAW, 24'd0);
            write_reg(REG_COS_PITCH, 24'd16384); write_reg(REG_SIN_PITCH, 24'd0);
         end
         1: begin
            write_reg(REG_COS_YAW, 24'hFFC000); write_reg(REG_SIN_YAW, 24'hFFC000);
            write_reg(REG_COS_PITCH, 24'd16384); write_reg(REG_SIN_PITCH, 24'd16384);
         end
         2: begin
            write_reg(REG_COS_YAW, 24'h8000); write_reg(REG_SIN_YAW, 24'h7FFF);
            write_reg(REG_COS_PITCH, 24'h7FFF); write_reg(REG_SIN_PITCH, 24'h8000);
         end
         default: begin
            write_reg(REG_COS_YAW, 24'($urandom_range(32768) - 16384));
            write_reg(REG_SIN_YAW, 24'($urandom_range(32768) - 16384));
            write_reg(REG_COS_PITCH, 24'($urandom_range(32768) - 16384));
            write_reg(REG_SIN_PITCH, 24'($urandom_range(32768) - 16384));
         end
      endcase
      write_reg(REG_CAM_X, kind == 1 ? 24'h800000 : 24'($signed(16'($urandom))));
      write_reg(REG_CAM_Y, kind == 2 ? 24'h7FFFFF : 24'($signed(16'($urandom))));
      write_reg(REG_CAM_Z, 24'($signed(14'($urandom))) - 24'sd20000);
      write_reg(REG_FOCAL, kind == 1 ? 24'hFFFFFF : kind == 2 ? 24'd0 : 24'($urandom));
   endtask

   initial begin
      cos_y = 16384; sin_y = 0; cos_p = 16384; sin_p = 0;
      cx = 2560; cy = 1280; cz = 0; focal = 106416;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed vectors at reset configuration.
      foreach (vec_table[i])
         send_vertex(vec_table[i].px, vec_table[i].py, vec_table[i].pz, vec_table[i].last,
                     vec_table[i].typed, vec_table[i].want);
      drain();
      // An unused index is not possible with a 3-bit address; all eight are written below.

      for (int ph = 0; ph < 5; ph++) begin
         send_idle = pct_send[ph];
         recv_stall = pct_recv[ph];
         for (int c = 0; c < 4; c++) begin
            random_config(ph == 0 ? c : 3);
            repeat (65) send_vertex(rand_coord(), rand_coord(), rand_coord(),
                                    1'($urandom), 1'b0, '{default:0});
            drain();
         end
      end
      done = 1'b1;

      $display("Covered %0d vertices, %0d results checked across 20 camera and angle settings.",
               sent, checked);
      if (mismatches == 0 && pending_points.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
